/* design/pcnms_pkg.sv */
// Shared types and constants for the per-class NMS engine.
package pcnms_pkg;

  localparam int unsigned DefMaxCandidates = 64;
  localparam logic [15:0] DefOverlapThreshold = 16'd29491;
  localparam int unsigned EntryW = 88;

  typedef struct packed {
    logic [15:0] box_left;
    logic [15:0] box_top;
    logic [15:0] box_right;
    logic [15:0] box_bottom;
    logic [7:0]  category;
    logic [15:0] score;
    logic        final_item;
  } nms_in_t;

  typedef struct packed {
    logic [15:0] kept_left;
    logic [15:0] kept_top;
    logic [15:0] kept_right;
    logic [15:0] kept_bottom;
    logic [7:0]  kept_category;
    logic [15:0] kept_score;
    logic        none_kept;
    logic        overflowed;
    logic        end_of_run;
  } nms_out_t;

  // One stored detection, as kept in both the load store and the kept list.
  typedef struct packed {
    logic [15:0] score;
    logic [7:0]  category;
    logic [15:0] bottom;
    logic [15:0] right;
    logic [15:0] top;
    logic [15:0] left;
  } entry_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_SCAN,
    B_FETCH,
    B_CAND,
    B_CHECK,
    B_COMMIT,
    B_EMIT_RD,
    B_EMIT_WAIT
  } back_state_e;

  function automatic logic [15:0] extent(logic [15:0] lo, logic [15:0] hi);
    return (hi > lo) ? (hi - lo) : 16'd0;
  endfunction

endpackage

/* design/pcnms_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module pcnms_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* design/pcnms_fifo.sv */
// Two-entry queue of run descriptors between the load front and the back end.
module pcnms_fifo #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  input  logic             pop_i,
  output logic             valid_o,
  output logic             full_o,
  output logic [WIDTH-1:0] head_o
);

  logic [WIDTH-1:0] slot_q [2];
  logic       wptr_q, wptr_d;
  logic       rptr_q, rptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign valid_o = (cnt_q != 2'd0);
  assign full_o  = (cnt_q == 2'd2);
  assign head_o  = slot_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wptr_d = wptr_q ^ do_push;
    rptr_d = rptr_q ^ do_pop;
    cnt_d  = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wptr_q] <= push_data_i;
    end
  end

endmodule

/* design/pcnms_front.sv */
// Load front: writes detections into the store and queues a run on the last one.
module pcnms_front #(
  parameter int unsigned MAX_CANDIDATES = pcnms_pkg::DefMaxCandidates
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  pcnms_pkg::nms_in_t                  in_data_i,
  input  logic                                store_busy_i,
  output logic                                we_o,
  output logic [$clog2(MAX_CANDIDATES)-1:0]   waddr_o,
  output pcnms_pkg::entry_t                   wdata_o,
  output logic                                push_o,
  output logic [$clog2(MAX_CANDIDATES+1):0]   push_data_o
);
  import pcnms_pkg::*;

  localparam int unsigned IdxW = $clog2(MAX_CANDIDATES);
  localparam int unsigned CntW = $clog2(MAX_CANDIDATES + 1);
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_CANDIDATES);

  logic [CntW-1:0] cnt_q, cnt_d;
  logic            ovf_q, ovf_d;
  logic            accept, has_room;

  assign in_ready_o = !store_busy_i;
  assign accept     = in_valid_i && in_ready_o;
  assign has_room   = (cnt_q < MaxCnt);

  assign we_o            = accept && has_room;
  assign waddr_o         = cnt_q[IdxW-1:0];
  assign wdata_o.score    = in_data_i.score;
  assign wdata_o.category = in_data_i.category;
  assign wdata_o.bottom   = in_data_i.box_bottom;
  assign wdata_o.right    = in_data_i.box_right;
  assign wdata_o.top      = in_data_i.box_top;
  assign wdata_o.left     = in_data_i.box_left;

  always_comb begin
    cnt_d  = cnt_q;
    ovf_d  = ovf_q;
    push_o = 1'b0;
    if (accept) begin
      if (has_room) begin
        cnt_d = cnt_q + CntW'(1);
      end else begin
        ovf_d = 1'b1;
      end
    end
    push_data_o = {ovf_d, cnt_d};
    if (accept && in_data_i.final_item) begin
      push_o = 1'b1;
      cnt_d  = '0;
      ovf_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      ovf_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      ovf_q <= ovf_d;
    end
  end

endmodule

/* design/pcnms_back.sv */
// Back end: score-ordered selection, overlap check against the kept list, emission.
module pcnms_back #(
  parameter int unsigned MAX_CANDIDATES = pcnms_pkg::DefMaxCandidates
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [15:0]                         thr_i,
  input  logic                                run_valid_i,
  input  logic [$clog2(MAX_CANDIDATES+1):0]   run_data_i,
  output logic                                run_pop_o,
  output logic [$clog2(MAX_CANDIDATES)-1:0]   store_raddr_o,
  input  pcnms_pkg::entry_t                   store_rdata_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output pcnms_pkg::nms_out_t                 out_data_o
);
  import pcnms_pkg::*;

  localparam int unsigned IdxW = $clog2(MAX_CANDIDATES);
  localparam int unsigned CntW = $clog2(MAX_CANDIDATES + 1);

  back_state_e state_q, state_d;
  logic [CntW-1:0] n_q, n_d, pass_q, pass_d, m_q, m_d, sa_q, sa_d, ka_q, ka_d, ea_q, ea_d;
  logic            ovf_q, ovf_d, sv_q, sv_d, found_q, found_d, hit_q, hit_d;
  logic [IdxW-1:0] sidx_q, sidx_d, best_q, best_d;
  logic [15:0]     best_sc_q, best_sc_d;
  logic [MAX_CANDIDATES-1:0] picked_q, picked_d;
  entry_t          cand_q, cand_d;
  logic            v1_q, v1_d, v2_q, v2_d, v3_q, v3_d, ok2_q, ok2_d, ok3_q, ok3_d;
  logic [31:0]     inter2_q, inter2_d, aa_q, aa_d, ab_q, ab_d, inter3_q, inter3_d;
  logic [32:0]     uni3_q, uni3_d;
  logic            out_valid_q, out_valid_d;
  nms_out_t        out_q, out_d;

  entry_t          krd;
  logic [EntryW-1:0] krd_raw;
  logic            kwe;
  logic [IdxW-1:0] kraddr;

  // stage 1 terms
  logic [15:0] il, it, ir, ib, iw, ih;
  logic        hit3, issue_k, issue_s, chk_done, last_pass;
  logic [48:0] lhs, rhs;

  pcnms_ram #(.WIDTH(EntryW), .DEPTH(MAX_CANDIDATES)) u_kept (
    .clk_i   (clk_i),
    .we_i    (kwe),
    .waddr_i (m_q[IdxW-1:0]),
    .wdata_i (cand_q),
    .raddr_i (kraddr),
    .rdata_o (krd_raw)
  );
  assign krd = entry_t'(krd_raw);

  assign kraddr = (state_q == B_CHECK) ? ka_q[IdxW-1:0] : ea_q[IdxW-1:0];
  assign store_raddr_o = (state_q == B_SCAN) ? sa_q[IdxW-1:0] : best_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    il = (krd.left > cand_q.left) ? krd.left : cand_q.left;
    it = (krd.top > cand_q.top) ? krd.top : cand_q.top;
    ir = (krd.right < cand_q.right) ? krd.right : cand_q.right;
    ib = (krd.bottom < cand_q.bottom) ? krd.bottom : cand_q.bottom;
    iw = extent(il, ir);
    ih = extent(it, ib);
    lhs = {1'b0, inter3_q, 16'd0};
    rhs = 49'(thr_i) * 49'(uni3_q);
    hit3 = v3_q && ok3_q && (uni3_q != 33'd0) && (lhs > rhs);
  end

  always_comb begin
    state_d     = state_q;
    n_d         = n_q;
    ovf_d       = ovf_q;
    pass_d      = pass_q;
    m_d         = m_q;
    sa_d        = sa_q;
    ka_d        = ka_q;
    ea_d        = ea_q;
    sv_d        = 1'b0;
    sidx_d      = sa_q[IdxW-1:0];
    found_d     = found_q;
    best_d      = best_q;
    best_sc_d   = best_sc_q;
    picked_d    = picked_q;
    cand_d      = cand_q;
    hit_d       = hit_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    run_pop_o   = 1'b0;
    kwe         = 1'b0;
    issue_s     = 1'b0;
    issue_k     = 1'b0;
    chk_done    = 1'b0;
    last_pass   = (pass_q + CntW'(1) == n_q);

    // overlap pipeline, always advancing
    v1_d     = 1'b0;
    v2_d     = v1_q;
    ok2_d    = (krd.category == cand_q.category) && (iw != 16'd0) && (ih != 16'd0);
    inter2_d = 32'(iw) * 32'(ih);
    aa_d     = 32'(extent(krd.left, krd.right)) * 32'(extent(krd.top, krd.bottom));
    ab_d     = 32'(extent(cand_q.left, cand_q.right)) * 32'(extent(cand_q.top, cand_q.bottom));
    v3_d     = v2_q;
    ok3_d    = ok2_q;
    inter3_d = inter2_q;
    uni3_d   = {1'b0, aa_q} + {1'b0, ab_q} - {1'b0, inter2_q};

    unique case (state_q)
      B_IDLE: begin
        if (run_valid_i) begin
          n_d     = run_data_i[CntW-1:0];
          ovf_d   = run_data_i[CntW];
          pass_d  = '0;
          m_d     = '0;
          sa_d    = '0;
          found_d = 1'b0;
          state_d = B_SCAN;
        end
      end
      B_SCAN: begin
        issue_s = (sa_q < n_q);
        sa_d    = sa_q + {{(CntW-1){1'b0}}, issue_s};
        sv_d    = issue_s;
        // strict compare keeps the earliest index on equal scores
        if (sv_q && !picked_q[sidx_q] &&
            (!found_q || store_rdata_i.score > best_sc_q)) begin
          found_d   = 1'b1;
          best_d    = sidx_q;
          best_sc_d = store_rdata_i.score;
        end
        if (!issue_s && !sv_q) begin
          state_d = B_FETCH;
        end
      end
      B_FETCH: begin
        picked_d[best_q] = 1'b1;
        state_d = B_CAND;
      end
      B_CAND: begin
        cand_d  = store_rdata_i;
        ka_d    = '0;
        hit_d   = 1'b0;
        state_d = B_CHECK;
      end
      B_CHECK: begin
        issue_k  = (ka_q < m_q) && !hit_q && !hit3;
        ka_d     = ka_q + {{(CntW-1){1'b0}}, issue_k};
        v1_d     = issue_k;
        hit_d    = hit_q | hit3;
        chk_done = ((ka_q == m_q) || hit_q) && !v1_q && !v2_q && !v3_q;
        if (chk_done) begin
          state_d = B_COMMIT;
        end
      end
      B_COMMIT: begin
        kwe    = !hit_q;
        m_d    = m_q + {{(CntW-1){1'b0}}, !hit_q};
        pass_d = pass_q + CntW'(1);
        if (last_pass) begin
          run_pop_o = 1'b1;
          ea_d      = '0;
          if (m_d == '0) begin
            out_d            = '0;
            out_d.none_kept  = 1'b1;
            out_d.overflowed = ovf_q;
            out_d.end_of_run = 1'b1;
            out_valid_d      = 1'b1;
            state_d          = B_EMIT_WAIT;
          end else begin
            state_d = B_EMIT_RD;
          end
        end else begin
          sa_d    = '0;
          found_d = 1'b0;
          state_d = B_SCAN;
        end
      end
      B_EMIT_RD: begin
        // kept list data for ea_q lands next cycle; load on the second visit
        if (v1_q) begin
          out_d.kept_left     = krd.left;
          out_d.kept_top      = krd.top;
          out_d.kept_right    = krd.right;
          out_d.kept_bottom   = krd.bottom;
          out_d.kept_category = krd.category;
          out_d.kept_score    = krd.score;
          out_d.none_kept     = 1'b0;
          out_d.overflowed    = ovf_q;
          out_d.end_of_run    = (ea_q + CntW'(1) == m_q);
          out_valid_d         = 1'b1;
          state_d             = B_EMIT_WAIT;
        end else begin
          v1_d = 1'b1;
        end
      end
      B_EMIT_WAIT: begin
        if (out_valid_q && out_ready_i) begin
          out_valid_d = 1'b0;
          if (out_q.end_of_run) begin
            picked_d = '0;
            m_d      = '0;
            state_d  = B_IDLE;
          end else begin
            ea_d    = ea_q + CntW'(1);
            state_d = B_EMIT_RD;
          end
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      n_q         <= '0;
      ovf_q       <= 1'b0;
      pass_q      <= '0;
      m_q         <= '0;
      sa_q        <= '0;
      ka_q        <= '0;
      ea_q        <= '0;
      sv_q        <= 1'b0;
      found_q     <= 1'b0;
      hit_q       <= 1'b0;
      picked_q    <= '0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      n_q         <= n_d;
      ovf_q       <= ovf_d;
      pass_q      <= pass_d;
      m_q         <= m_d;
      sa_q        <= sa_d;
      ka_q        <= ka_d;
      ea_q        <= ea_d;
      sv_q        <= sv_d;
      found_q     <= found_d;
      hit_q       <= hit_d;
      picked_q    <= picked_d;
      v1_q        <= v1_d;
      v2_q        <= v2_d;
      v3_q        <= v3_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sidx_q    <= sidx_d;
    best_q    <= best_d;
    best_sc_q <= best_sc_d;
    cand_q    <= cand_d;
    ok2_q     <= ok2_d;
    ok3_q     <= ok3_d;
    inter2_q  <= inter2_d;
    aa_q      <= aa_d;
    ab_q      <= ab_d;
    inter3_q  <= inter3_d;
    uni3_q    <= uni3_d;
    out_q     <= out_d;
  end

  a_kept_le_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_q <= pass_q)
    else $error("kept list longer than visited candidates");

  a_check_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_CHECK) |-> (pass_q < n_q))
    else $error("overlap check past end of run");

  a_pop_to_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_pop_o |=> (state_q == B_EMIT_RD || state_q == B_EMIT_WAIT))
    else $error("store released without entering emission");

  a_picked_on_fetch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_FETCH) |=> picked_q[$past(best_q)])
    else $error("selected candidate not marked");

endmodule

/* design/per_class_nms_engine.sv */
// Top level of the per-class greedy non-maximum suppression engine.
//
// Input channel (in_valid_i/in_ready_o, in_data_i): one detection per transaction.
// The transaction with final_item set closes the set and starts suppression.
// Loads beyond MAX_CANDIDATES are taken but dropped and reported as overflowed.
// Output channel (out_valid_o/out_ready_i, out_data_o): kept detections in order of
// descending score, ties in load order; end_of_run marks the last one. A set that
// keeps nothing yields one transaction with none_kept set.
// cfg_we_i/cfg_wdata_i write the overlap threshold; write it only while idle.
// Loads are taken at one per cycle while in_ready_o is high. After the final load,
// ordering and checking are paced by the single-port score scan, run once per
// stored detection, and by the one-entry-per-cycle kept list scan; each result is
// then read from the kept list and held until the receiver takes it.
// The next set may be loaded as soon as emission starts; a stalled receiver holds
// the engine in emission. Reset clears counters and marks and sets the threshold
// to its default; the detection store needs no clearing.
module per_class_nms_engine #(
  parameter int unsigned MAX_CANDIDATES = pcnms_pkg::DefMaxCandidates
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [15:0]         cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  pcnms_pkg::nms_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output pcnms_pkg::nms_out_t out_data_o
);
  import pcnms_pkg::*;

  localparam int unsigned IdxW = $clog2(MAX_CANDIDATES);
  localparam int unsigned DescW = $clog2(MAX_CANDIDATES + 1) + 1;

  logic [15:0]       thr_q;
  logic              st_we;
  logic [IdxW-1:0]   st_waddr, st_raddr;
  entry_t            st_wdata, st_rdata;
  logic [EntryW-1:0] st_rdata_raw;
  logic              push, pop, q_valid, q_full;
  logic [DescW-1:0]  push_data, q_head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= DefOverlapThreshold;
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  pcnms_front #(.MAX_CANDIDATES(MAX_CANDIDATES)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .store_busy_i (q_valid || q_full),
    .we_o         (st_we),
    .waddr_o      (st_waddr),
    .wdata_o      (st_wdata),
    .push_o       (push),
    .push_data_o  (push_data)
  );

  pcnms_ram #(.WIDTH(EntryW), .DEPTH(MAX_CANDIDATES)) u_store (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata_raw)
  );
  assign st_rdata = entry_t'(st_rdata_raw);

  pcnms_fifo #(.WIDTH(DescW)) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .full_o      (q_full),
    .head_o      (q_head)
  );

  pcnms_back #(.MAX_CANDIDATES(MAX_CANDIDATES)) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .thr_i         (thr_q),
    .run_valid_i   (q_valid),
    .run_data_i    (q_head),
    .run_pop_o     (pop),
    .store_raddr_o (st_raddr),
    .store_rdata_i (st_rdata),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_data_o    (out_data_o)
  );

endmodule
